FILE: src/jtss_pkg.sv
package jtss_pkg;

   // command codes carried in req_type
   localparam logic [2:0] CMD_RESET  = 3'd0;
   localparam logic [2:0] CMD_IR8    = 3'd1;
   localparam logic [2:0] CMD_DR16   = 3'd2;
   localparam logic [2:0] CMD_DR20   = 3'd3;
   localparam logic [2:0] CMD_STROBE = 3'd4;

   // microcode field codes
   localparam logic [1:0] TMS_0  = 2'd0;
   localparam logic [1:0] TMS_1  = 2'd1;
   localparam logic [1:0] TMS_CZ = 2'd2;   // high when the bit counter is spent

   localparam logic [1:0] TDI_TCLK = 2'd0;
   localparam logic [1:0] TDI_ONE  = 2'd1;
   localparam logic [1:0] TDI_DATA = 2'd2;

   localparam logic [1:0] LAST_NO  = 2'd0;
   localparam logic [1:0] LAST_YES = 2'd1;
   localparam logic [1:0] LAST_CZ  = 2'd2;

   localparam logic [1:0] TCLK_KEEP = 2'd0;
   localparam logic [1:0] TCLK_SET  = 2'd1;
   localparam logic [1:0] TCLK_CLR  = 2'd2;

   localparam logic [1:0] SEQ_NEXT    = 2'd0;
   localparam logic [1:0] SEQ_JNZ     = 2'd1;   // jump while counter non-zero, else fall through
   localparam logic [1:0] SEQ_JNZ_END = 2'd2;   // jump while counter non-zero, else finish
   localparam logic [1:0] SEQ_END     = 2'd3;

   localparam int UC_AW = 4;
   localparam logic [UC_AW-1:0] UC_RESET  = 4'd0;
   localparam logic [UC_AW-1:0] UC_IR     = 4'd3;
   localparam logic [UC_AW-1:0] UC_DR     = 4'd4;
   localparam logic [UC_AW-1:0] UC_DATA   = 4'd7;
   localparam logic [UC_AW-1:0] UC_STROBE = 4'd10;
   localparam logic [UC_AW-1:0] UC_LAST   = 4'd10;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [19:0] shift_data;
      logic [19:0] tdo_response;
      logic [5:0]  strobe_count;
   } req_word_type;

   typedef struct packed {
      logic        tms_level;
      logic        tdi_level;
      logic        is_tck_pulse;
      logic [19:0] captured_word;
      logic        last_pulse;
   } rsp_word_type;

   // one control word per program step
   typedef struct packed {
      logic [1:0]       tms_sel;
      logic [1:0]       tdi_sel;
      logic             tck;
      logic [1:0]       last_sel;
      logic             word_en;
      logic             cnt_step;
      logic [1:0]       tclk_op;
      logic [1:0]       seq;
      logic [UC_AW-1:0] target;
   } ctrl_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic cnt_zero;
      logic out_free;
   } stat_type;

   function automatic ctrl_type jtss_rom(input logic [UC_AW-1:0] addr);
      ctrl_type c;
      c = '{TMS_0, TDI_TCLK, 1'b1, LAST_NO, 1'b0, 1'b0, TCLK_KEEP, SEQ_END, UC_RESET};
      unique case (addr)
         // TAP reset: six TMS high, two TMS low, TDI high throughout
         4'd0:  c = '{TMS_1, TDI_ONE, 1'b1, LAST_NO, 1'b0, 1'b1, TCLK_KEEP, SEQ_JNZ, 4'd0};
         4'd1:  c = '{TMS_0, TDI_ONE, 1'b1, LAST_NO, 1'b0, 1'b0, TCLK_KEEP, SEQ_NEXT, 4'd0};
         4'd2:  c = '{TMS_0, TDI_ONE, 1'b1, LAST_YES, 1'b0, 1'b0, TCLK_SET, SEQ_END, 4'd0};
         // IR preamble has an extra TMS high pulse, then joins the DR path
         4'd3:  c = '{TMS_1, TDI_TCLK, 1'b1, LAST_NO, 1'b0, 1'b0, TCLK_KEEP, SEQ_NEXT, 4'd0};
         4'd4:  c = '{TMS_1, TDI_TCLK, 1'b1, LAST_NO, 1'b0, 1'b0, TCLK_KEEP, SEQ_NEXT, 4'd0};
         4'd5:  c = '{TMS_0, TDI_TCLK, 1'b1, LAST_NO, 1'b0, 1'b0, TCLK_KEEP, SEQ_NEXT, 4'd0};
         4'd6:  c = '{TMS_0, TDI_TCLK, 1'b1, LAST_NO, 1'b0, 1'b0, TCLK_KEEP, SEQ_NEXT, 4'd0};
         // data bits, MSB first, TMS high on the last
         4'd7:  c = '{TMS_CZ, TDI_DATA, 1'b1, LAST_NO, 1'b0, 1'b1, TCLK_KEEP, SEQ_JNZ, UC_DATA};
         // exit, update, back to idle
         4'd8:  c = '{TMS_1, TDI_TCLK, 1'b1, LAST_NO, 1'b0, 1'b0, TCLK_KEEP, SEQ_NEXT, 4'd0};
         4'd9:  c = '{TMS_0, TDI_TCLK, 1'b1, LAST_YES, 1'b1, 1'b0, TCLK_KEEP, SEQ_END, 4'd0};
         // TCLK strobes on TDI
         4'd10: c = '{TMS_0, TDI_ONE, 1'b0, LAST_CZ, 1'b0, 1'b1, TCLK_CLR, SEQ_JNZ_END,
                      UC_STROBE};
         default: c = '{TMS_0, TDI_TCLK, 1'b1, LAST_NO, 1'b0, 1'b0, TCLK_KEEP, SEQ_END,
                        UC_RESET};
      endcase
      return c;
   endfunction

endpackage

FILE: src/jtag_tap_shift_sequencer_top.sv
// The accepted command is registered in the sequencer, and each pulse word is then
// registered in the output register. Throughput: one pulse word per cycle while
// rsp_ready is high; the microcode step counter is the bottleneck, one step a pulse.
// Reset: synchronous, clears the sequencer, output valid and stored TCLK level.
module jtag_tap_shift_sequencer_top #(
   parameter int MAX_STROBES = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  jtss_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output jtss_pkg::rsp_word_type rsp_word
);
   import jtss_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   logic     step;
   logic     busy;
   logic     accept;

   // one command at a time
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   jtss_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .stat     (stat),
      .ctrl     (ctrl),
      .step     (step),
      .busy     (busy)
   );

   jtss_datapath #(
      .MAX_STROBES (MAX_STROBES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_word),
      .ctrl      (ctrl),
      .step      (step),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: src/jtss_sequencer.sv
module jtss_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  jtss_pkg::req_word_type req_word,
   input  jtss_pkg::stat_type     stat,
   output jtss_pkg::ctrl_type     ctrl,
   output logic                   step,
   output logic                   busy
);
   import jtss_pkg::*;

   logic             busy_ff, busy_in;
   logic [UC_AW-1:0] pc_ff, pc_in;
   logic             launch;
   logic [UC_AW-1:0] entry;

   // entry point per command; unknown types and empty strobe bursts give nothing
   always_comb begin
      launch = 1'b1;
      entry  = UC_RESET;
      unique case (req_word.req_type) inside
         CMD_RESET:         entry = UC_RESET;
         CMD_IR8:           entry = UC_IR;
         CMD_DR16, CMD_DR20: entry = UC_DR;
         CMD_STROBE: begin
            entry  = UC_STROBE;
            launch = (req_word.strobe_count != 6'd0);
         end
         default:           launch = 1'b0;
      endcase
   end

   assign ctrl = jtss_rom(pc_ff);
   assign step = busy_ff & stat.out_free;
   assign busy = busy_ff;

   // step counter and jumps
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (accept && launch) begin
         busy_in = 1'b1;
         pc_in   = entry;
      end else if (step) begin
         unique case (ctrl.seq)
            SEQ_NEXT: pc_in = pc_ff + 1'b1;
            SEQ_JNZ:  pc_in = stat.cnt_zero ? pc_ff + 1'b1 : ctrl.target;
            SEQ_JNZ_END: begin
               if (stat.cnt_zero) busy_in = 1'b0;
               else pc_in = ctrl.target;
            end
            default:  busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= UC_RESET;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= UC_LAST)
      else $error("program counter beyond microcode");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      step && ctrl.seq == SEQ_END |=> !busy_ff)
      else $error("sequencer still busy after end step");

endmodule

FILE: src/jtss_datapath.sv
module jtss_datapath #(
   parameter int MAX_STROBES = 63
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  jtss_pkg::req_word_type req_word,
   input  jtss_pkg::ctrl_type     ctrl,
   input  logic                   step,
   output jtss_pkg::stat_type     stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output jtss_pkg::rsp_word_type rsp_word
);
   import jtss_pkg::*;

   logic [5:0]   cnt_ff, cnt_in;
   logic [19:0]  sr_ff, sr_in;
   logic [19:0]  cap_ff, cap_in;
   logic         tclk_ff, tclk_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic [5:0]   n_strobe;
   logic         cnt_zero;

   assign n_strobe = (req_word.strobe_count > 6'(MAX_STROBES)) ? 6'(MAX_STROBES)
                                                               : req_word.strobe_count;
   assign cnt_zero = (cnt_ff == 6'd0);

   // load counter, MSB-aligned data and capture word on accept; step while running
   always_comb begin
      cnt_in = cnt_ff;
      sr_in  = sr_ff;
      cap_in = cap_ff;
      if (accept) begin
         unique case (req_word.req_type)
            CMD_IR8: begin
               cnt_in = 6'd7;
               sr_in  = {req_word.shift_data[7:0], 12'd0};
               cap_in = {12'd0, req_word.tdo_response[7:0]};
            end
            CMD_DR16: begin
               cnt_in = 6'd15;
               sr_in  = {req_word.shift_data[15:0], 4'd0};
               cap_in = {4'd0, req_word.tdo_response[15:0]};
            end
            CMD_DR20: begin
               cnt_in = 6'd19;
               sr_in  = req_word.shift_data;
               cap_in = {req_word.tdo_response[3:0], req_word.tdo_response[19:4]};
            end
            CMD_STROBE: cnt_in = n_strobe - 6'd1;
            default:    cnt_in = 6'd5;   // TAP reset: six TMS high pulses
         endcase
      end else if (step && ctrl.cnt_step) begin
         cnt_in = cnt_ff - 6'd1;
         sr_in  = {sr_ff[18:0], 1'b0};
      end
   end

   // stored TCLK level
   always_comb begin
      tclk_in = tclk_ff;
      if (step) begin
         case (ctrl.tclk_op)
            TCLK_SET: tclk_in = 1'b1;
            TCLK_CLR: tclk_in = 1'b0;
            default:  tclk_in = tclk_ff;
         endcase
      end
   end

   // pulse word build
   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (step) begin
         case (ctrl.tms_sel)
            TMS_1:   rsp_word_in.tms_level = 1'b1;
            TMS_CZ:  rsp_word_in.tms_level = cnt_zero;
            default: rsp_word_in.tms_level = 1'b0;
         endcase
         case (ctrl.tdi_sel)
            TDI_ONE:  rsp_word_in.tdi_level = 1'b1;
            TDI_DATA: rsp_word_in.tdi_level = sr_ff[19];
            default:  rsp_word_in.tdi_level = tclk_ff;
         endcase
         case (ctrl.last_sel)
            LAST_YES: rsp_word_in.last_pulse = 1'b1;
            LAST_CZ:  rsp_word_in.last_pulse = cnt_zero;
            default:  rsp_word_in.last_pulse = 1'b0;
         endcase
         rsp_word_in.is_tck_pulse  = ctrl.tck;
         rsp_word_in.captured_word = ctrl.word_en ? cap_ff : 20'd0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tclk_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tclk_ff      <= tclk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      sr_ff       <= sr_in;
      cap_ff      <= cap_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign stat.cnt_zero = cnt_zero;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_word_ff;

   a_word_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.last_pulse |-> rsp_word_ff.captured_word == 20'd0)
      else $error("capture word shown before the final pulse");

   a_strobe_low: assert property (@(posedge clock) disable iff (reset)
      step && ctrl.tclk_op == TCLK_CLR |=> !tclk_ff)
      else $error("TCLK level not low after strobe");

endmodule

FILE: sim/tb.sv
module tb;

   import jtss_pkg::*;

   // request codes the block must ignore
   localparam logic [2:0] CMD_NONE_A = 3'd5;
   localparam logic [2:0] CMD_NONE_C = 3'd7;
   localparam logic [2:0] CMD_NONE_B = 3'd6;

   localparam int MAX_STROBES    = 63;
   localparam int N_DIRECTED     = 20;
   localparam int N_RANDOM       = 110;
   localparam int N_CALM         = 30;     // final random words with no idling
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   // one row of the directed table: command word, optional typed final pulse
   typedef struct {
      req_word_type cmd;
      bit           typed;
      rsp_word_type final_pulse;
   } cmd_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   // typed final pulse travelling alongside the current request word
   bit           cur_typed;
   rsp_word_type cur_final;

   bit           bursts_on;
   logic         tap_tclk;
   rsp_word_type pulse_q[$];
   int           mismatches;
   int           pulses_checked;
   int           cmds_seen[8];
   int           quiet_cycles;

   cmd_row_type directed_tab [0:N_DIRECTED-1] = '{
      // shifts before any TAP reset: TDI idles low
      '{'{CMD_IR8,    20'h000A5, 20'h00000, 6'd0},  1'b0, '0},
      '{'{CMD_DR16,   20'h0C3C3, 20'h0F0F0, 6'd17}, 1'b0, '0},
      '{'{CMD_RESET,  20'hFFFFF, 20'hFFFFF, 6'd63}, 1'b1, '{1'b0, 1'b1, 1'b1, 20'h00000, 1'b1}},
      // capture extremes, unused upper TDO bits set
      '{'{CMD_IR8,    20'hFFFFF, 20'hFFFFF, 6'd0},  1'b1, '{1'b0, 1'b1, 1'b1, 20'h000FF, 1'b1}},
      '{'{CMD_DR16,   20'h00000, 20'hFFFFF, 6'd63}, 1'b1, '{1'b0, 1'b1, 1'b1, 20'h0FFFF, 1'b1}},
      '{'{CMD_DR20,   20'hFFFFF, 20'h0000F, 6'd0},  1'b1, '{1'b0, 1'b1, 1'b1, 20'hF0000, 1'b1}},
      '{'{CMD_DR20,   20'h00000, 20'hFFFFF, 6'd0},  1'b1, '{1'b0, 1'b1, 1'b1, 20'hFFFFF, 1'b1}},
      '{'{CMD_STROBE, 20'h00000, 20'h00000, 6'd1},  1'b1, '{1'b0, 1'b1, 1'b0, 20'h00000, 1'b1}},
      '{'{CMD_DR20,   20'h80001, 20'h12345, 6'd5},  1'b0, '0},
      // zero strobes and unknown codes give no pulses
      '{'{CMD_STROBE, 20'hFFFFF, 20'hFFFFF, 6'd0},  1'b0, '0},
      '{'{CMD_NONE_A, 20'h12345, 20'h54321, 6'd9},  1'b0, '0},
      '{'{CMD_NONE_B, 20'h00000, 20'h00000, 6'd0},  1'b0, '0},
      '{'{CMD_NONE_C, 20'hFFFFF, 20'hFFFFF, 6'd63}, 1'b0, '0},
      '{'{CMD_STROBE, 20'h00000, 20'h00000, 6'd63}, 1'b1, '{1'b0, 1'b1, 1'b0, 20'h00000, 1'b1}},
      '{'{CMD_DR16,   20'h08001, 20'h05A5A, 6'd2},  1'b0, '0},
      '{'{CMD_RESET,  20'h00000, 20'h00000, 6'd0},  1'b1, '{1'b0, 1'b1, 1'b1, 20'h00000, 1'b1}},
      '{'{CMD_STROBE, 20'h00000, 20'h00000, 6'd0},  1'b0, '0},
      '{'{CMD_DR16,   20'h0AAAA, 20'h05555, 6'd0},  1'b0, '0},
      '{'{CMD_IR8,    20'h00001, 20'h00080, 6'd0},  1'b0, '0},
      '{'{CMD_STROBE, 20'h55555, 20'hAAAAA, 6'd2},  1'b0, '0}
   };

   jtag_tap_shift_sequencer_top #(.MAX_STROBES(MAX_STROBES)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------
   // Pulse predictor
   // ---------------------------------------------------------------
   function automatic void push_pulse(logic tms, logic tdi, logic tck, logic [19:0] word,
                                      logic last);
      rsp_word_type p;
      p.tms_level     = tms;
      p.tdi_level     = tdi;
      p.is_tck_pulse  = tck;
      p.captured_word = word;
      p.last_pulse    = last;
      pulse_q.push_back(p);
   endfunction

   // expand one accepted command into the pulse words it should produce
   function automatic void expand_command(req_word_type c);
      int          nbits;
      int          nstrobe;
      logic [19:0] cap;
      case (c.req_type)
         CMD_RESET: begin
            for (int i = 0; i < 8; i++)
               push_pulse(i < 6, 1'b1, 1'b1, 20'd0, i == 7);
            tap_tclk = 1'b1;
         end
         CMD_STROBE: begin
            nstrobe = (c.strobe_count > MAX_STROBES) ? MAX_STROBES : c.strobe_count;
            if (nstrobe != 0) begin
               for (int j = 0; j < nstrobe; j++)
                  push_pulse(1'b0, 1'b1, 1'b0, 20'd0, j == nstrobe - 1);
               tap_tclk = 1'b0;
            end
         end
         CMD_IR8, CMD_DR16, CMD_DR20: begin
            nbits = (c.req_type == CMD_IR8) ? 8 : (c.req_type == CMD_DR16) ? 16 : 20;
            // walk to Shift-IR or Shift-DR
            push_pulse(1'b1, tap_tclk, 1'b1, 20'd0, 1'b0);
            if (c.req_type == CMD_IR8)
               push_pulse(1'b1, tap_tclk, 1'b1, 20'd0, 1'b0);
            push_pulse(1'b0, tap_tclk, 1'b1, 20'd0, 1'b0);
            push_pulse(1'b0, tap_tclk, 1'b1, 20'd0, 1'b0);
            // data, MSB first, exit on the last bit
            for (int i = nbits - 1; i >= 0; i--)
               push_pulse(i == 0, c.shift_data[i], 1'b1, 20'd0, 1'b0);
            case (c.req_type)
               CMD_IR8:  cap = {12'd0, c.tdo_response[7:0]};
               CMD_DR16: cap = {4'd0, c.tdo_response[15:0]};
               default:  cap = {c.tdo_response[3:0], c.tdo_response[19:4]};
            endcase
            // update, then back to idle
            push_pulse(1'b1, tap_tclk, 1'b1, 20'd0, 1'b0);
            push_pulse(1'b0, tap_tclk, 1'b1, cap, 1'b1);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge, plus watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      int           depth;
      rsp_word_type want;
      if (!reset) begin
         quiet_cycles++;
         if (req_valid && req_ready) begin
            depth = pulse_q.size();
            cmds_seen[req_word.req_type]++;
            expand_command(req_word);
            if (cur_typed && pulse_q.size() > depth)
               pulse_q[pulse_q.size() - 1] = cur_final;
            quiet_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            quiet_cycles = 0;
            if (pulse_q.size() == 0) begin
               $display("%0t: unexpected pulse word, expected none got %h", $time, rsp_word);
               mismatches++;
            end else begin
               want = pulse_q.pop_front();
               pulses_checked++;
               check_field("tms_level",     20'(want.tms_level),    20'(rsp_word.tms_level));
               check_field("tdi_level",     20'(want.tdi_level),    20'(rsp_word.tdi_level));
               check_field("is_tck_pulse",  20'(want.is_tck_pulse),
                           20'(rsp_word.is_tck_pulse));
               check_field("captured_word", want.captured_word, rsp_word.captured_word);
               check_field("last_pulse",    20'(want.last_pulse),   20'(rsp_word.last_pulse));
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, nothing accepted for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result side: ready drops in random bursts
   // ---------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Command side
   // ---------------------------------------------------------------
   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_cmd(req_word_type c, bit typed, rsp_word_type fin);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= c;
      cur_typed <= typed;
      cur_final <= fin;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      @(negedge clock);
   endtask

   // random command, weighted towards well-formed shifts and short bursts
   function automatic req_word_type random_cmd();
      req_word_type c;
      int           pick;
      c.shift_data   = 20'($urandom);
      c.tdo_response = 20'($urandom);
      c.strobe_count = 6'($urandom);
      pick = $urandom_range(0, 13);
      if (pick == 0)
         c.req_type = CMD_RESET;
      else if (pick <= 3)
         c.req_type = CMD_IR8;
      else if (pick <= 6)
         c.req_type = CMD_DR16;
      else if (pick <= 9)
         c.req_type = CMD_DR20;
      else if (pick <= 12)
         c.req_type = CMD_STROBE;
      else
         c.req_type = 3'($urandom_range(CMD_NONE_A, CMD_NONE_C));
      if (c.req_type == CMD_STROBE) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            c.strobe_count = 6'd0;
         else if (pick == 1)
            c.strobe_count = 6'(MAX_STROBES);
         else
            c.strobe_count = 6'($urandom_range(1, 8));
      end
      return c;
   endfunction

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_word       = '0;
      rsp_ready      = 1'b0;
      cur_typed      = 1'b0;
      cur_final      = '0;
      bursts_on      = 1'b1;
      tap_tclk       = 1'b0;
      mismatches     = 0;
      pulses_checked = 0;
      quiet_cycles   = 0;
      foreach (cmds_seen[k]) cmds_seen[k] = 0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < N_DIRECTED; r++)
         send_cmd(directed_tab[r].cmd, directed_tab[r].typed, directed_tab[r].final_pulse);

      // random commands, the last stretch at full rate on both sides
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - N_CALM)
            bursts_on = 1'b0;
         send_cmd(random_cmd(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      cur_typed <= 1'b0;

      // drain, then give the block time to show any stray word
      while (pulse_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Commands: %0d TAP reset, %0d IR8, %0d DR16, %0d DR20, %0d strobe, %0d ignored",
               cmds_seen[CMD_RESET], cmds_seen[CMD_IR8], cmds_seen[CMD_DR16],
               cmds_seen[CMD_DR20], cmds_seen[CMD_STROBE],
               cmds_seen[CMD_NONE_A] + cmds_seen[CMD_NONE_B] + cmds_seen[CMD_NONE_C]);
      $display("Pulse words checked: %0d, with random stalls on both channels", pulses_checked);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
